[rtl/kgrq_pkg.sv]
`timescale 1ns / 1ps
// kgrq_pkg: shared types, sizes and codes of the keypoint grid radius query block
// no dependencies; imported by every module of the block except kgrq_ram

package kgrq_pkg;

  localparam int GRID_COLS  = 32;
  localparam int GRID_ROWS  = 32;
  localparam int CELL_SLOTS = 8;
  localparam int MAX_POINTS = 1024;
  localparam int MAX_RUN    = 64;
  localparam int CELL_RESET = 20;

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int ENTRIES = CELLS * CELL_SLOTS;
  localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int GC_W    = $clog2(GRID_COLS + 1);
  localparam int GR_W    = $clog2(GRID_ROWS + 1);
  localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W  = $clog2(CELL_SLOTS + 1);
  localparam int ID_W    = $clog2(MAX_POINTS);
  localparam int TOT_W   = $clog2(MAX_POINTS + 1);
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  localparam int PT_W    = 24;

  // shared divider sizes
  localparam int DIV_W     = 16;
  localparam int DVS_W     = 12;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] REG_CELL_W  = 2'd0;
  localparam logic [1:0] REG_CELL_H  = 2'd1;
  localparam logic [1:0] REG_IMAGE_W = 2'd2;
  localparam logic [1:0] REG_IMAGE_H = 2'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CELL_FULL  = 3'd1,
    ST_STORE_FULL = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_TRUNC      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    JOB_GCOLS, JOB_GROWS, JOB_CX, JOB_CY, JOB_RW, JOB_RH
  } job_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_INS_CHK, S_INS_RD, S_INS_WR,
    S_Q_BOUND, S_Q_RDFILL, S_Q_FILL, S_Q_RDENT, S_Q_RDPT, S_Q_HIT, S_Q_ADV,
    S_Q_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        has_candidate;
    logic [9:0]  keypoint_id;
    logic [11:0] cand_x;
    logic [11:0] cand_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic             rem_nz;
  } div_rsp_t;

  function automatic out_item_t plain_item(input status_t st);
    out_item_t it;
    it = '0;
    it.status = st;
    it.last = 1'b1;
    return it;
  endfunction

endpackage

[rtl/keypoint_grid_radius_query.sv]
`timescale 1ns / 1ps
// keypoint_grid_radius_query: grid index over keypoints with insert, clear and radius query
// depends on kgrq_pkg, kgrq_div and kgrq_ram
// one request at a time; all divisions share one divider
// insert: four divisions, then the cell read unless rejected before it (outside or store full)
// clear: fill memory sweep; query: six divisions, then a walk over the cells of the window
// and the keypoints found; reset: sync active low, fill memory sweep with in_ready low

module keypoint_grid_radius_query (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kgrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kgrq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import kgrq_pkg::*;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  logic [7:0]  cw_r, ch_r;
  logic [11:0] iw_r, ih_r;
  logic [7:0]  cw_eff, ch_eff;

  in_item_t    item_r, item_nxt;
  logic [GC_W-1:0]  gc_r, gc_nxt;
  logic [GR_W-1:0]  gr_r, gr_nxt;
  logic [11:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [12:0]      rw_r, rw_nxt, rh_r, rh_nxt;
  logic [COL_W-1:0] w_r, w_nxt, whi_r, whi_nxt;
  logic [ROW_W-1:0] h_r, h_nxt, hlo_r, hlo_nxt, hhi_r, hhi_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, slot_r, slot_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             ready_r, ready_nxt;
  logic [CELL_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_rsp_r, clr_rsp_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [ID_W-1:0]  held_id_r, held_id_nxt;
  logic [11:0]      held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_free;
  logic             cfg_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CELL_W-1:0] cell_addr;
  logic              fill_we;
  logic [CELL_W-1:0] fill_waddr;
  logic [FILL_W-1:0] fill_wdata, fill_rdata;
  logic              ent_we;
  logic [ENT_W-1:0]  ent_waddr, ent_raddr;
  logic [ID_W-1:0]   ent_rdata;
  logic              pt_we;
  logic [PT_W-1:0]   pt_rdata;

  logic signed [14:0] lo_x, hi_x, lo_y, hi_y, gcm1, grm1, lo_cx, hi_cx, lo_cy, hi_cy;
  out_item_t          held_item;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 8'(CELL_RESET);
      ch_r <= 8'(CELL_RESET);
      iw_r <= 12'd640;
      ih_r <= 12'd480;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_CELL_W:  cw_r <= pwdata[7:0];
        REG_CELL_H:  ch_r <= pwdata[7:0];
        REG_IMAGE_W: iw_r <= pwdata[11:0];
        REG_IMAGE_H: ih_r <= pwdata[11:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CELL_W:  prdata = {24'd0, cw_r};
      REG_CELL_H:  prdata = {24'd0, ch_r};
      REG_IMAGE_W: prdata = {20'd0, iw_r};
      REG_IMAGE_H: prdata = {20'd0, ih_r};
      default:     prdata = '0;
    endcase
  end

  assign cw_eff = (cw_r == 8'd0) ? 8'd1 : cw_r;
  assign ch_eff = (ch_r == 8'd0) ? 8'd1 : ch_r;

  // shared divider
  kgrq_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    div_req.start = (state_r == S_DIV_GO);
    unique case (job_r)
      JOB_GCOLS: begin
        div_req.dividend = 16'(iw_r);
        div_req.divisor  = 12'(cw_eff);
      end
      JOB_GROWS: begin
        div_req.dividend = 16'(ih_r);
        div_req.divisor  = 12'(ch_eff);
      end
      JOB_CX: begin
        div_req.dividend = 16'(item_r.pos_x);
        div_req.divisor  = 12'(cw_eff);
      end
      JOB_CY: begin
        div_req.dividend = 16'(item_r.pos_y);
        div_req.divisor  = 12'(ch_eff);
      end
      JOB_RW: begin
        div_req.dividend = item_r.radius;
        div_req.divisor  = {cw_eff, 4'd0};
      end
      JOB_RH: begin
        div_req.dividend = item_r.radius;
        div_req.divisor  = {ch_eff, 4'd0};
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = 12'd1;
      end
    endcase
  end

  // memories
  assign cell_addr = CELL_W'(int'(w_r) * GRID_ROWS + int'(h_r));
  assign ent_raddr = ENT_W'(int'(cell_addr) * CELL_SLOTS + int'(slot_r));

  kgrq_ram #(.WIDTH(FILL_W), .DEPTH(CELLS)) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .raddr(cell_addr),
    .rdata(fill_rdata)
  );

  kgrq_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(total_r[ID_W-1:0]),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  kgrq_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk  (clk),
    .we   (pt_we),
    .waddr(total_r[ID_W-1:0]),
    .wdata({item_r.pos_y, item_r.pos_x}),
    .raddr(ent_rdata),
    .rdata(pt_rdata)
  );

  // query window
  always_comb begin
    gcm1  = 15'(gc_r) - 15'sd1;
    grm1  = 15'(gr_r) - 15'sd1;
    lo_x  = $signed({3'd0, cx_r}) - $signed({2'd0, rw_r});
    hi_x  = $signed({3'd0, cx_r}) + $signed({2'd0, rw_r});
    lo_y  = $signed({3'd0, cy_r}) - $signed({2'd0, rh_r});
    hi_y  = $signed({3'd0, cy_r}) + $signed({2'd0, rh_r});
    lo_cx = (lo_x < 0) ? 15'sd0 : lo_x;
    lo_cy = (lo_y < 0) ? 15'sd0 : lo_y;
    hi_cx = (hi_x > gcm1) ? gcm1 : hi_x;
    hi_cy = (hi_y > grm1) ? grm1 : hi_y;
  end

  always_comb begin
    held_item = '0;
    held_item.status        = ST_OK;
    held_item.has_candidate = 1'b1;
    held_item.keypoint_id   = 10'(held_id_r);
    held_item.cand_x        = held_x_r;
    held_item.cand_y        = held_y_r;
  end

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    item_nxt    = item_r;
    gc_nxt      = gc_r;
    gr_nxt      = gr_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    rw_nxt      = rw_r;
    rh_nxt      = rh_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    whi_nxt     = whi_r;
    hlo_nxt     = hlo_r;
    hhi_nxt     = hhi_r;
    fill_nxt    = fill_r;
    slot_nxt    = slot_r;
    total_nxt   = total_r;
    ready_nxt   = ready_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_rsp_nxt = clr_rsp_r;
    run_nxt     = run_r;
    held_id_nxt = held_id_r;
    held_x_nxt  = held_x_r;
    held_y_nxt  = held_y_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fill_we     = 1'b0;
    fill_waddr  = cell_addr;
    fill_wdata  = fill_rdata + 1'b1;
    ent_we      = 1'b0;
    ent_waddr   = ENT_W'(int'(cell_addr) * CELL_SLOTS + int'(fill_rdata));
    pt_we       = 1'b0;
    in_ready    = (state_r == S_IDLE);

    unique case (state_r)
      S_CLR: begin
        fill_we     = 1'b1;
        fill_waddr  = clr_cnt_r;
        fill_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CELL_W'(CELLS - 1)) begin
          clr_cnt_nxt = '0;
          if (clr_rsp_r) begin
            res_nxt   = plain_item(ST_OK);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          job_nxt  = JOB_GCOLS;
          if (in_data.opcode == OP_CLEAR) begin
            total_nxt   = '0;
            ready_nxt   = 1'b0;
            clr_cnt_nxt = '0;
            clr_rsp_nxt = 1'b1;
            state_nxt   = S_CLR;
          end else if (in_data.opcode == OP_INSERT) begin
            state_nxt = S_DIV_GO;
          end else if (in_data.opcode == OP_QUERY) begin
            if (ready_r) begin
              state_nxt = S_DIV_GO;
            end else begin
              res_nxt   = plain_item(ST_EMPTY);
              state_nxt = S_EMIT;
            end
          end else begin
            res_nxt   = plain_item(ST_OK);
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (job_r)
            JOB_GCOLS: gc_nxt = (div_rsp.quot > 16'(GRID_COLS)) ?
                                GC_W'(GRID_COLS) : div_rsp.quot[GC_W-1:0];
            JOB_GROWS: gr_nxt = (div_rsp.quot > 16'(GRID_ROWS)) ?
                                GR_W'(GRID_ROWS) : div_rsp.quot[GR_W-1:0];
            JOB_CX:    cx_nxt = div_rsp.quot[11:0];
            JOB_CY:    cy_nxt = div_rsp.quot[11:0];
            JOB_RW:    rw_nxt = div_rsp.quot[12:0] + 13'(div_rsp.rem_nz);
            JOB_RH:    rh_nxt = div_rsp.quot[12:0] + 13'(div_rsp.rem_nz);
            default:   ;
          endcase
          if (job_r == JOB_CY && item_r.opcode == OP_INSERT) begin
            state_nxt = S_INS_CHK;
          end else if (job_r == JOB_RH) begin
            state_nxt = S_Q_BOUND;
          end else begin
            job_nxt   = job_t'(job_r + 3'd1);
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_INS_CHK: begin
        if (cx_r >= 12'(gc_r) || cy_r >= 12'(gr_r)) begin
          res_nxt   = plain_item(ST_OUTSIDE);
          state_nxt = S_EMIT;
        end else if (total_r >= TOT_W'(MAX_POINTS)) begin
          res_nxt   = plain_item(ST_STORE_FULL);
          state_nxt = S_EMIT;
        end else begin
          w_nxt     = cx_r[COL_W-1:0];
          h_nxt     = cy_r[ROW_W-1:0];
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        if (fill_rdata >= FILL_W'(CELL_SLOTS)) begin
          res_nxt = plain_item(ST_CELL_FULL);
        end else begin
          fill_we   = 1'b1;
          ent_we    = 1'b1;
          pt_we     = 1'b1;
          total_nxt = total_r + 1'b1;
          ready_nxt = 1'b1;
          res_nxt   = '0;
          res_nxt.status        = ST_OK;
          res_nxt.has_candidate = 1'b1;
          res_nxt.keypoint_id   = 10'(total_r[ID_W-1:0]);
          res_nxt.cand_x        = item_r.pos_x;
          res_nxt.cand_y        = item_r.pos_y;
          res_nxt.last          = 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_Q_BOUND: begin
        run_nxt = '0;
        if (hi_cx < lo_cx || hi_cy < lo_cy) begin
          state_nxt = S_Q_FIN;
        end else begin
          w_nxt     = lo_cx[COL_W-1:0];
          whi_nxt   = hi_cx[COL_W-1:0];
          h_nxt     = lo_cy[ROW_W-1:0];
          hlo_nxt   = lo_cy[ROW_W-1:0];
          hhi_nxt   = hi_cy[ROW_W-1:0];
          state_nxt = S_Q_RDFILL;
        end
      end
      S_Q_RDFILL: begin
        state_nxt = S_Q_FILL;
      end
      S_Q_FILL: begin
        fill_nxt  = fill_rdata;
        slot_nxt  = '0;
        state_nxt = (fill_rdata == '0) ? S_Q_ADV : S_Q_RDENT;
      end
      S_Q_RDENT: begin
        state_nxt = S_Q_RDPT;
      end
      S_Q_RDPT: begin
        state_nxt = S_Q_HIT;
      end
      S_Q_HIT: begin
        if (run_r == RUN_W'(MAX_RUN)) begin
          res_nxt        = held_item;
          res_nxt.status = ST_TRUNC;
          res_nxt.last   = 1'b1;
          state_nxt      = S_EMIT;
        end else if (run_r == '0 || out_free) begin
          if (run_r != '0) begin
            out_nxt       = held_item;
            out_valid_nxt = 1'b1;
          end
          held_id_nxt = ent_rdata;
          held_x_nxt  = pt_rdata[11:0];
          held_y_nxt  = pt_rdata[23:12];
          run_nxt     = run_r + 1'b1;
          slot_nxt    = slot_r + 1'b1;
          state_nxt   = (slot_r + 1'b1 < fill_r) ? S_Q_RDENT : S_Q_ADV;
        end
      end
      S_Q_ADV: begin
        if (h_r < hhi_r) begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_Q_RDFILL;
        end else if (w_r < whi_r) begin
          w_nxt     = w_r + 1'b1;
          h_nxt     = hlo_r;
          state_nxt = S_Q_RDFILL;
        end else begin
          state_nxt = S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        if (run_r != '0) begin
          res_nxt      = held_item;
          res_nxt.last = 1'b1;
        end else begin
          res_nxt = plain_item(ST_OK);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          clr_rsp_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
      ready_r     <= 1'b0;
      clr_cnt_r   <= '0;
      clr_rsp_r   <= 1'b0;
      run_r       <= '0;
      job_r       <= JOB_GCOLS;
    end else begin
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      ready_r     <= ready_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      run_r       <= run_nxt;
      job_r       <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    gc_r      <= gc_nxt;
    gr_r      <= gr_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    rw_r      <= rw_nxt;
    rh_r      <= rh_nxt;
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    whi_r     <= whi_nxt;
    hlo_r     <= hlo_nxt;
    hhi_r     <= hhi_nxt;
    fill_r    <= fill_nxt;
    slot_r    <= slot_nxt;
    held_id_r <= held_id_nxt;
    held_x_r  <= held_x_nxt;
    held_y_r  <= held_y_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/kgrq_ram.sv]
`timescale 1ns / 1ps
// kgrq_ram: generic single write, single read memory with registered read
// no dependencies

module kgrq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kgrq_div.sv]
`timescale 1ns / 1ps
// kgrq_div: shared restoring divider, one quotient bit per cycle
// depends on kgrq_pkg

module kgrq_div (
  input  logic               clk,
  input  logic               rst_n,
  input  kgrq_pkg::div_req_t req,
  output kgrq_pkg::div_rsp_t rsp
);
  import kgrq_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       diff;
  logic                 take;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    take     = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      rem_nxt = take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = quo_r;
  assign rsp.rem_nz = |rem_r;

endmodule

[rtl/kgrq_checker.sv]
`timescale 1ns / 1ps
// kgrq_checker: port-level assertions for keypoint_grid_radius_query, with its bind
// depends on kgrq_pkg

module kgrq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kgrq_pkg::out_item_t out_data
);
  import kgrq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_candidate |->
      out_data.keypoint_id == '0 && out_data.cand_x == '0 && out_data.cand_y == '0)
    else $error("fields set without candidate");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TRUNC |-> out_data.last && out_data.has_candidate)
    else $error("truncation not on final candidate");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK && out_data.status != ST_TRUNC |->
      out_data.last && !out_data.has_candidate)
    else $error("error status on a candidate");

endmodule

bind keypoint_grid_radius_query kgrq_checker u_kgrq_checker (.*);
